// ===== rtl/packet_reorder_receiver_assert.svh =====
// Assertion macros shared by the receiver RTL.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef PACKET_REORDER_RECEIVER_ASSERT_SVH
`define PACKET_REORDER_RECEIVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PRR_ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("receiver check failed in the same cycle");
`define PRR_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("receiver check failed in the following cycle");
`else
`define PRR_ASSERT_SAME(label, clk, rst_n, cond, cons)
`define PRR_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif
`endif

// ===== rtl/prr_pkg.sv =====
package prr_pkg;

	localparam int SEQ_W  = 31;
	localparam int SIZE_W = 11;

	localparam int DEF_REORDER_DEPTH = 10;
	localparam int DEF_MAX_PAYLOAD   = 1456;
	localparam int DEF_HANDLE_BITS   = 8;

	typedef enum logic [1:0] {
		KIND_RELEASE = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_EOF_ACK = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_RELEASE,
		ST_ACK
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap;       // capture the accepted header
		logic ins;       // insert the captured header into the store
		logic pop;       // drop the head entry of the store
		logic emit_rel;  // send the head entry as a release and advance the expected number
		logic emit_ack;  // send the closing ack
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic eligible;   // size within limit and not below the expected number
		logic is_exp;     // header carries the expected number
		logic head_valid;
		logic head_lt;    // head entry is below the expected number
		logic head_eq;    // head entry is the expected one
		logic out_free;   // output register can take a result this cycle
	} sts_t;

endpackage

// ===== rtl/prr_in_if.sv =====
interface prr_in_if import prr_pkg::*; #(
	parameter int HANDLE_BITS = DEF_HANDLE_BITS
);
	logic                   valid;
	logic                   ready;
	logic [SEQ_W-1:0]       seq_number;
	logic [SIZE_W-1:0]      payload_size;
	logic [HANDLE_BITS-1:0] payload_handle;

	modport source (output valid, output seq_number, output payload_size,
		output payload_handle, input ready);
	modport sink (input valid, input seq_number, input payload_size,
		input payload_handle, output ready);
endinterface

// ===== rtl/prr_out_if.sv =====
interface prr_out_if import prr_pkg::*; #(
	parameter int HANDLE_BITS = DEF_HANDLE_BITS
);
	logic                   valid;
	logic                   ready;
	kind_t                  result_kind;
	logic [SEQ_W-1:0]       released_seq;
	logic [SIZE_W-1:0]      released_size;
	logic [HANDLE_BITS-1:0] released_handle;
	logic [SEQ_W-1:0]       ack_number;
	logic                   last_of_run;

	modport source (output valid, output result_kind, output released_seq,
		output released_size, output released_handle, output ack_number,
		output last_of_run, input ready);
	modport sink (input valid, input result_kind, input released_seq,
		input released_size, input released_handle, input ack_number,
		input last_of_run, output ready);
endinterface

// ===== rtl/prr_dp.sv =====
module prr_dp import prr_pkg::*; #(
	parameter int REORDER_DEPTH = DEF_REORDER_DEPTH,
	parameter int MAX_PAYLOAD   = DEF_MAX_PAYLOAD,
	parameter int HANDLE_BITS   = DEF_HANDLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic [SEQ_W-1:0]       seq_number,
	input  logic [SIZE_W-1:0]      payload_size,
	input  logic [HANDLE_BITS-1:0] payload_handle,
	prr_out_if.source              res
);

	localparam int IdxW = $clog2(REORDER_DEPTH);

	logic [SEQ_W-1:0]       pkt_seq_q;
	logic [SIZE_W-1:0]      pkt_size_q;
	logic [HANDLE_BITS-1:0] pkt_handle_q;
	logic [SEQ_W-1:0]       exp_q;

	logic                   slot_valid_q  [REORDER_DEPTH];
	logic [SEQ_W-1:0]       slot_seq_q    [REORDER_DEPTH];
	logic [SIZE_W-1:0]      slot_size_q   [REORDER_DEPTH];
	logic [HANDLE_BITS-1:0] slot_handle_q [REORDER_DEPTH];

	logic                   out_valid_q;
	kind_t                  out_kind_q;
	logic [SEQ_W-1:0]       out_seq_q;
	logic [SIZE_W-1:0]      out_size_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [SEQ_W-1:0]       out_ack_q;
	logic                   out_last_q;

	logic            dup;
	logic            pos_found;
	logic [IdxW-1:0] pos;
	logic            do_ins;

	// Duplicate search and insertion point; the lowest matching slot wins.
	always_comb begin
		dup       = 1'b0;
		pos_found = 1'b0;
		pos       = '0;
		for (int i = REORDER_DEPTH - 1; i >= 0; i--) begin
			if (slot_valid_q[i] && slot_seq_q[i] == pkt_seq_q) begin
				dup = 1'b1;
			end
			if (!slot_valid_q[i] || slot_seq_q[i] > pkt_seq_q) begin
				pos_found = 1'b1;
				pos       = IdxW'(i);
			end
		end
	end

	assign do_ins = cmd.ins && !dup && pos_found;

	assign sts.eligible   = (pkt_size_q <= SIZE_W'(MAX_PAYLOAD)) && (pkt_seq_q >= exp_q);
	assign sts.is_exp     = (pkt_seq_q == exp_q);
	assign sts.head_valid = slot_valid_q[0];
	assign sts.head_lt    = (slot_seq_q[0] < exp_q);
	assign sts.head_eq    = (slot_seq_q[0] == exp_q);
	assign sts.out_free   = !out_valid_q || res.ready;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			pkt_seq_q    <= seq_number;
			pkt_size_q   <= payload_size;
			pkt_handle_q <= payload_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (cmd.emit_rel) begin
			exp_q <= exp_q + SEQ_W'(slot_size_q[0]);
		end
	end

	// Valid bits stay a prefix: insertion shifts the tail up, a pop shifts all down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < REORDER_DEPTH; j++) begin
				slot_valid_q[j] <= 1'b0;
			end
		end else if (do_ins) begin
			if (pos == '0) begin
				slot_valid_q[0] <= 1'b1;
			end
			for (int j = 1; j < REORDER_DEPTH; j++) begin
				if (IdxW'(j) == pos) begin
					slot_valid_q[j] <= 1'b1;
				end else if (IdxW'(j) > pos && slot_valid_q[j-1]) begin
					slot_valid_q[j] <= 1'b1;
				end
			end
		end else if (cmd.pop) begin
			for (int j = 0; j < REORDER_DEPTH - 1; j++) begin
				slot_valid_q[j] <= slot_valid_q[j+1];
			end
			slot_valid_q[REORDER_DEPTH-1] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_ins) begin
			if (pos == '0) begin
				slot_seq_q[0]    <= pkt_seq_q;
				slot_size_q[0]   <= pkt_size_q;
				slot_handle_q[0] <= pkt_handle_q;
			end
			for (int j = 1; j < REORDER_DEPTH; j++) begin
				if (IdxW'(j) == pos) begin
					slot_seq_q[j]    <= pkt_seq_q;
					slot_size_q[j]   <= pkt_size_q;
					slot_handle_q[j] <= pkt_handle_q;
				end else if (IdxW'(j) > pos && slot_valid_q[j-1]) begin
					slot_seq_q[j]    <= slot_seq_q[j-1];
					slot_size_q[j]   <= slot_size_q[j-1];
					slot_handle_q[j] <= slot_handle_q[j-1];
				end
			end
		end else if (cmd.pop) begin
			for (int j = 0; j < REORDER_DEPTH - 1; j++) begin
				slot_seq_q[j]    <= slot_seq_q[j+1];
				slot_size_q[j]   <= slot_size_q[j+1];
				slot_handle_q[j] <= slot_handle_q[j+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_rel || cmd.emit_ack) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_rel) begin
			out_kind_q   <= KIND_RELEASE;
			out_seq_q    <= slot_seq_q[0];
			out_size_q   <= slot_size_q[0];
			out_handle_q <= slot_handle_q[0];
			out_ack_q    <= '0;
			out_last_q   <= 1'b0;
		end else if (cmd.emit_ack) begin
			out_kind_q   <= (pkt_size_q == '0) ? KIND_EOF_ACK : KIND_ACK;
			out_seq_q    <= '0;
			out_size_q   <= '0;
			out_handle_q <= '0;
			out_ack_q    <= exp_q;
			out_last_q   <= 1'b1;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.result_kind     = out_kind_q;
	assign res.released_seq    = out_seq_q;
	assign res.released_size   = out_size_q;
	assign res.released_handle = out_handle_q;
	assign res.ack_number      = out_ack_q;
	assign res.last_of_run     = out_last_q;

endmodule

// ===== rtl/prr_ctrl.sv =====
module prr_ctrl import prr_pkg::*; #(
	parameter int REORDER_DEPTH = DEF_REORDER_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int CntW = $clog2(REORDER_DEPTH + 1);

	state_t          state_q;
	state_t          state_d;
	logic [CntW-1:0] iter_q;
	logic            rel_done;

	// The release pass ends on an empty store, a gap at the head, or a full sweep.
	assign rel_done = (iter_q == CntW'(REORDER_DEPTH)) || !sts.head_valid
		|| (!sts.head_lt && !sts.head_eq);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				state_d = (sts.eligible && sts.is_exp) ? ST_RELEASE : ST_ACK;
			end
			ST_RELEASE: begin
				if (rel_done) begin
					state_d = ST_ACK;
				end
			end
			ST_ACK: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.cap  = in_valid;
			end
			ST_INSERT: begin
				cmd.ins = sts.eligible;
			end
			ST_RELEASE: begin
				if (!rel_done) begin
					if (sts.head_lt) begin
						cmd.pop = 1'b1;
					end else if (sts.out_free) begin
						cmd.pop      = 1'b1;
						cmd.emit_rel = 1'b1;
					end
				end
			end
			ST_ACK: begin
				cmd.emit_ack = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INSERT) begin
				iter_q <= '0;
			end else if (cmd.pop) begin
				iter_q <= iter_q + CntW'(1);
			end
		end
	end

endmodule

// ===== rtl/packet_reorder_receiver.sv =====
// Reorder receiver for a byte-sequenced packet stream. Each input item is one packet header
// (sequence number, payload size, payload handle); the payload itself stays in external
// memory and is named by its handle. A header below the expected number, a duplicate of a
// stored header, or one whose size exceeds MAX_PAYLOAD is dropped. Others are kept in a
// sorted store of REORDER_DEPTH entries, the largest falling off when it is full. When the
// header carries the expected number, the contiguous run at the head of the store comes out
// as release items in order, each advancing the expected number by its size. Every input
// closes with exactly one ack item (an end-of-file ack when the size is zero) with
// last_of_run set. An item is captured when taken and inserted in the cycle after.
// A header that is not at the expected number then goes straight to the ack state.
// A header at the expected number starts the release pass, which takes the released or
// stale head entries one at a time (at most REORDER_DEPTH) and then sees that the pass is
// over before the ack state. The pass shifts the store down by one entry per cycle; a stale
// entry is dropped without waiting, while a released one waits until the single output
// register is free, so back-pressure on the output stalls the pass. The next item is taken
// while the last ack still waits in the output register.
`include "packet_reorder_receiver_assert.svh"

module packet_reorder_receiver import prr_pkg::*; #(
	parameter int REORDER_DEPTH = DEF_REORDER_DEPTH,
	parameter int MAX_PAYLOAD   = DEF_MAX_PAYLOAD,
	parameter int HANDLE_BITS   = DEF_HANDLE_BITS
) (
	input logic       clk,
	input logic       arst_n,
	prr_in_if.sink    pkt,
	prr_out_if.source res
);

	// Commands and status between the sequencer and the store.
	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign pkt.ready = in_ready;

	// The controller walks each item through capture, insertion, the release pass and the ack.
	prr_ctrl #(
		.REORDER_DEPTH(REORDER_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(pkt.valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// The datapath holds the expected number, the sorted store and the output register.
	prr_dp #(
		.REORDER_DEPTH(REORDER_DEPTH),
		.MAX_PAYLOAD  (MAX_PAYLOAD),
		.HANDLE_BITS  (HANDLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.seq_number    (pkt.seq_number),
		.payload_size  (pkt.payload_size),
		.payload_handle(pkt.payload_handle),
		.res           (res)
	);

	// A release only leaves the store when its head is exactly the expected number.
	`PRR_ASSERT_SAME(a_rel_head, clk, arst_n, cmd.emit_rel, sts.head_valid && sts.head_eq)
	// Nothing is written into the output register while it holds an untaken result.
	`PRR_ASSERT_SAME(a_emit_free, clk, arst_n, cmd.emit_rel || cmd.emit_ack, sts.out_free)
	// The last result of an input is always an ack, never a release.
	`PRR_ASSERT_SAME(a_last_ack, clk, arst_n, res.valid && res.last_of_run,
		res.result_kind != KIND_RELEASE)
	// Taking an item moves straight on to insertion; no new item enters behind it.
	`PRR_ASSERT_NEXT(a_one_item, clk, arst_n, pkt.valid && pkt.ready, !pkt.ready)

endmodule
